// ===== sv/tdbr_pkg.sv =====
// Shared types and constants for the triac dimmer with button ramp.
// Used by tdbr_ctrl and by the top level triac_dimmer_button_ramp.
// No dependencies.
package tdbr_pkg;

   // Kinds of item on the request channel.
   typedef enum logic [1:0] {
      ACT_TICK  = 2'd0,
      ACT_RADIO = 2'd1,
      ACT_ZC    = 2'd2,
      ACT_OVF   = 2'd3
   } action_type;

   // Radio command codes.
   localparam logic [7:0] CODE_ONOFF = 8'd10;
   localparam logic [7:0] CODE_LEVEL = 8'd11;

   localparam logic [15:0] TIMER_TOP = 16'hFFFF;
   localparam logic [7:0]  COUNT_SAT = 8'hFF;

   // Control register port.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_CLIENT_ID      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE_TICKS = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_PRESS     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RAMP_STEP      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_LEVEL      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_DELAY_PER_STEP = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_PULSE_WIDTH    = 3'd6;

   // Reset values of the control registers and of the brightness.
   localparam logic [7:0]  RST_CLIENT_ID      = 8'd1;
   localparam logic [7:0]  RST_DEBOUNCE_TICKS = 8'd4;
   localparam logic [7:0]  RST_LONG_PRESS     = 8'd3;
   localparam logic [6:0]  RST_RAMP_STEP      = 7'd10;
   localparam logic [6:0]  RST_MAX_LEVEL      = 7'd100;
   localparam logic [8:0]  RST_DELAY_PER_STEP = 9'd133;
   localparam logic [15:0] RST_PULSE_WIDTH    = 16'd100;
   localparam logic [6:0]  RST_LEVEL          = 7'd30;

   typedef struct packed {
      logic [7:0]  client_id;
      logic [7:0]  debounce_ticks;
      logic [7:0]  long_press_count;
      logic [6:0]  ramp_step;
      logic [6:0]  max_level;
      logic [8:0]  delay_per_step;
      logic [15:0] pulse_width;
   } cfg_type;

   typedef struct packed {
      action_type  action;
      logic        button_pressed;
      logic [7:0]  target_id;
      logic [7:0]  command_code;
      logic [7:0]  command_value;
   } item_type;

   typedef struct packed {
      logic [6:0]  level;
      logic        switched_on;
      logic        zero_cross_enabled;
      logic        gate;
      logic [15:0] timer_load;
      logic        timer_load_valid;
      logic        timer_stop;
   } result_type;

endpackage

// ===== sv/tdbr_ctrl.sv =====
// Dimmer state and its update for one item, registered when fire is high.
// Depends on tdbr_pkg for the item, config and result structs.
module tdbr_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               fire,
   input  tdbr_pkg::cfg_type  cfg,
   input  tdbr_pkg::item_type item,
   output tdbr_pkg::result_type result
);
   import tdbr_pkg::*;

   logic [6:0]  level_ff, level_in;
   logic        on_ff, on_in;
   logic        zc_ff, zc_in;
   logic [15:0] delay_ff, delay_in;
   logic        pending_ff, pending_in;
   logic        gate_ff, gate_in;
   logic [7:0]  ticks_ff, ticks_in;
   logic        fresh_ff, fresh_in;
   logic [7:0]  held_ff, held_in;
   logic        ramp_down_ff, ramp_down_in;
   logic        prev_ff, prev_in;

   logic [7:0]  ticks_inc;
   logic [7:0]  ramp_sum;
   logic        do_switch, switch_on;
   logic        do_apply;
   logic [6:0]  apply_level;
   logic [6:0]  missing;
   logic [15:0] delay_product;
   logic [15:0] load;
   logic        load_valid, stop;

   always_comb begin
      level_in     = level_ff;
      on_in        = on_ff;
      zc_in        = zc_ff;
      delay_in     = delay_ff;
      pending_in   = pending_ff;
      gate_in      = gate_ff;
      ticks_in     = ticks_ff;
      fresh_in     = fresh_ff;
      held_in      = held_ff;
      ramp_down_in = ramp_down_ff;
      prev_in      = prev_ff;
      load         = '0;
      load_valid   = 1'b0;
      stop         = 1'b0;
      do_switch    = 1'b0;
      switch_on    = 1'b0;
      do_apply     = 1'b0;
      apply_level  = level_ff;
      ticks_inc    = (ticks_ff != COUNT_SAT) ? ticks_ff + 8'd1 : ticks_ff;
      ramp_sum     = {1'b0, level_ff} + {1'b0, cfg.ramp_step};

      case (item.action)
         ACT_TICK: begin
            ticks_in = ticks_inc;
            if (item.button_pressed) begin
               if (ticks_inc >= cfg.debounce_ticks) begin
                  ticks_in = '0;
                  if (fresh_ff) begin
                     fresh_in  = 1'b0;
                     do_switch = 1'b1;
                     switch_on = ~on_ff;
                  end else if (held_ff >= cfg.long_press_count) begin
                     if (!on_ff) begin
                        do_switch = 1'b1;
                        switch_on = 1'b1;
                     end else begin
                        // A step past either bound keeps the level and turns around.
                        do_apply = 1'b1;
                        if (ramp_down_ff) begin
                           if (level_ff >= cfg.ramp_step) begin
                              apply_level = level_ff - cfg.ramp_step;
                           end else begin
                              ramp_down_in = 1'b0;
                           end
                        end else begin
                           if (ramp_sum <= {1'b0, cfg.max_level}) begin
                              apply_level = ramp_sum[6:0];
                           end else begin
                              ramp_down_in = 1'b1;
                           end
                        end
                     end
                  end else if (held_ff != COUNT_SAT) begin
                     held_in = held_ff + 8'd1;
                  end
               end
            end else begin
               fresh_in = 1'b1;
               held_in  = '0;
               if (prev_ff) begin
                  ramp_down_in = ~ramp_down_ff;
               end
            end
            prev_in = item.button_pressed;
         end
         ACT_RADIO: begin
            if (item.target_id == cfg.client_id) begin
               if (item.command_code == CODE_ONOFF) begin
                  do_switch = 1'b1;
                  switch_on = (item.command_value != 8'd0);
               end else if (item.command_code == CODE_LEVEL) begin
                  do_apply = 1'b1;
                  apply_level = (item.command_value > {1'b0, cfg.max_level}) ?
                                cfg.max_level : item.command_value[6:0];
               end
            end
         end
         ACT_ZC: begin
            if (zc_ff) begin
               if (level_ff != 7'd0) begin
                  load       = delay_ff;
                  load_valid = 1'b1;
               end else begin
                  stop    = 1'b1;
                  gate_in = 1'b0;
               end
               pending_in = 1'b1;
            end
         end
         ACT_OVF: begin
            if (pending_ff) begin
               gate_in    = 1'b1;
               load       = TIMER_TOP - cfg.pulse_width;
               load_valid = 1'b1;
               pending_in = 1'b0;
            end else begin
               gate_in = 1'b0;
            end
         end
         default: begin
         end
      endcase

      if (do_switch) begin
         on_in = switch_on;
         zc_in = switch_on;
         if (!switch_on) begin
            stop    = 1'b1;
            gate_in = 1'b0;
         end
      end

      // A level above a lowered maximum counts as no missing steps.
      missing       = (cfg.max_level > apply_level) ? cfg.max_level - apply_level : 7'd0;
      delay_product = 16'(cfg.delay_per_step) * 16'(missing);

      if (do_apply) begin
         level_in = apply_level;
         delay_in = TIMER_TOP - delay_product;
         if (apply_level == 7'd0 || !on_in) begin
            zc_in   = 1'b0;
            gate_in = 1'b0;
         end else begin
            zc_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff     <= RST_LEVEL;
         on_ff        <= 1'b0;
         zc_ff        <= 1'b1;
         delay_ff     <= '0;
         pending_ff   <= 1'b0;
         gate_ff      <= 1'b0;
         ticks_ff     <= '0;
         fresh_ff     <= 1'b0;
         held_ff      <= '0;
         ramp_down_ff <= 1'b0;
         prev_ff      <= 1'b0;
      end else if (fire) begin
         level_ff     <= level_in;
         on_ff        <= on_in;
         zc_ff        <= zc_in;
         delay_ff     <= delay_in;
         pending_ff   <= pending_in;
         gate_ff      <= gate_in;
         ticks_ff     <= ticks_in;
         fresh_ff     <= fresh_in;
         held_ff      <= held_in;
         ramp_down_ff <= ramp_down_in;
         prev_ff      <= prev_in;
      end
   end

   always_comb begin
      result.level              = level_in;
      result.switched_on        = on_in;
      result.zero_cross_enabled = zc_in;
      result.gate               = gate_in;
      result.timer_load         = load;
      result.timer_load_valid   = load_valid;
      result.timer_stop         = stop;
   end

   // The gate only rises on a timer overflow that had a pulse pending.
   a_gate_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(gate_ff) |-> $past(fire && item.action == ACT_OVF && pending_ff))
      else $error("gate rose without a pending pulse overflow");

   // A pending pulse is only consumed by an overflow.
   a_pending_fall: assert property (@(posedge clock) disable iff (reset)
      $fell(pending_ff) |-> $past(fire && item.action == ACT_OVF))
      else $error("pulse pending cleared by something other than an overflow");

   // A switched-off dimmer never leaves zero crossings enabled.
   a_off_disarms: assert property (@(posedge clock) disable iff (reset)
      fire && do_switch && !switch_on |=> !zc_ff && !on_ff && !gate_ff)
      else $error("switch off left zero crossings or gate active");

endmodule

// ===== sv/triac_dimmer_button_ramp.sv =====
// Top level of the triac dimmer: request register, control register file,
// dimmer state update (tdbr_ctrl) and response register.
// Depends on tdbr_pkg and tdbr_ctrl.
//
// Usage: each request transfer on req_* carries one event: a button tick with
// the sampled button level, a radio command, a mains zero crossing, or a
// firing-timer overflow. Every request yields exactly one response transfer on
// rsp_* that shows the brightness, on/off mode, zero-crossing enable and gate
// level after the event, plus the timer load value and stop flag it caused.
// Control registers are written over csr_* (index 0 client id up to 6 pulse
// width) and always ready. The user must write them only while no request
// is in flight; the block does not enforce it. A request is registered in
// the request register on transfer and its result in the response register.
// Throughput: one request per cycle; the state update is a single pass of
// compare, add and one 9x7 multiply between the request and response
// registers, and each item depends only on the state left by the previous one.
// A stalled response holds the response register; the request register then
// fills and req_ready drops until rsp_ready returns.
// Reset (synchronous) empties both registers, loads the register reset values
// and sets brightness 30, switched off, zero crossings enabled.
module triac_dimmer_button_ramp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_action,
   input  logic                                 req_button_pressed,
   input  logic [7:0]                           req_target_id,
   input  logic [7:0]                           req_command_code,
   input  logic [7:0]                           req_command_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [6:0]                           rsp_level,
   output logic                                 rsp_switched_on,
   output logic                                 rsp_zero_cross_enabled,
   output logic                                 rsp_gate,
   output logic [15:0]                          rsp_timer_load,
   output logic                                 rsp_timer_load_valid,
   output logic                                 rsp_timer_stop,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [tdbr_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [tdbr_pkg::CSR_DATA_W-1:0]      csr_data
);
   import tdbr_pkg::*;

   cfg_type    cfg_ff;
   item_type   item_ff;
   logic       item_valid_ff;
   result_type result_ff;
   logic       rsp_valid_ff;
   result_type result;
   logic       fire;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.client_id        <= RST_CLIENT_ID;
         cfg_ff.debounce_ticks   <= RST_DEBOUNCE_TICKS;
         cfg_ff.long_press_count <= RST_LONG_PRESS;
         cfg_ff.ramp_step        <= RST_RAMP_STEP;
         cfg_ff.max_level        <= RST_MAX_LEVEL;
         cfg_ff.delay_per_step   <= RST_DELAY_PER_STEP;
         cfg_ff.pulse_width      <= RST_PULSE_WIDTH;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CLIENT_ID:      cfg_ff.client_id        <= csr_data[7:0];
            CSR_DEBOUNCE_TICKS: cfg_ff.debounce_ticks   <= csr_data[7:0];
            CSR_LONG_PRESS:     cfg_ff.long_press_count <= csr_data[7:0];
            CSR_RAMP_STEP:      cfg_ff.ramp_step        <= csr_data[6:0];
            CSR_MAX_LEVEL:      cfg_ff.max_level        <= csr_data[6:0];
            CSR_DELAY_PER_STEP: cfg_ff.delay_per_step   <= csr_data[8:0];
            CSR_PULSE_WIDTH:    cfg_ff.pulse_width      <= csr_data[15:0];
            default: begin
            end
         endcase
      end
   end

   // The request register advances whenever the response register is free
   // or is being emptied in the same cycle.
   assign fire      = item_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !item_valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_ready) begin
         item_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff.action         <= action_type'(req_action);
         item_ff.button_pressed <= req_button_pressed;
         item_ff.target_id      <= req_target_id;
         item_ff.command_code   <= req_command_code;
         item_ff.command_value  <= req_command_value;
      end
   end

   tdbr_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .cfg    (cfg_ff),
      .item   (item_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         result_ff <= result;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_level              = result_ff.level;
   assign rsp_switched_on        = result_ff.switched_on;
   assign rsp_zero_cross_enabled = result_ff.zero_cross_enabled;
   assign rsp_gate               = result_ff.gate;
   assign rsp_timer_load         = result_ff.timer_load;
   assign rsp_timer_load_valid   = result_ff.timer_load_valid;
   assign rsp_timer_stop         = result_ff.timer_stop;

   // Every processed request produces a response in the next cycle.
   a_fire_to_rsp: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid_ff)
      else $error("processed request produced no response");

   // A timer stop and a timer load never come from the same event.
   a_stop_xor_load: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(result_ff.timer_stop && result_ff.timer_load_valid))
      else $error("timer stopped and loaded by one event");

   // Without a valid load the load value reads as zero.
   a_load_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !result_ff.timer_load_valid |-> result_ff.timer_load == 16'd0)
      else $error("timer load nonzero while not valid");

endmodule
